>>> rtl/core/tbcs_pkg.sv
// Shared types and codes for the two-byte character stack with search.
// No dependencies; every other file in rtl/core refers to this package.
`default_nettype none

package tbcs_pkg;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_FIND  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } state_t;

    localparam int CHAR_W  = 16;
    localparam int FILL_W  = 7;

endpackage

`default_nettype wire

>>> rtl/core/tbcs_store.sv
// Character memory: one write port and one read port with registered read data.
// Uses tbcs_pkg for the character width.
`default_nettype none

module tbcs_store #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  wire logic                        clk,
    input  wire logic                        wr_en,
    input  wire logic [ADDR_W-1:0]           wr_addr,
    input  wire logic [tbcs_pkg::CHAR_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0]           rd_addr,
    output logic      [tbcs_pkg::CHAR_W-1:0] rd_data
);

    logic [tbcs_pkg::CHAR_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> rtl/core/tbcs_ctrl.sv
// Command sequencer: fill count, push and pop handling, and the entry-by-entry search.
// Uses tbcs_pkg; drives the ports of tbcs_store.
`default_nettype none

module tbcs_ctrl #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int CNT_W  = 7
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [1:0]                  func,
    input  wire logic [tbcs_pkg::CHAR_W-1:0] char_code,
    output logic                             busy,
    output logic                             done,
    output logic [1:0]                       status,
    output logic                             found,
    output logic [tbcs_pkg::FILL_W-1:0]      fill_level,
    output logic                             wr_en,
    output logic [ADDR_W-1:0]                wr_addr,
    output logic [tbcs_pkg::CHAR_W-1:0]      wr_data,
    output logic [ADDR_W-1:0]                rd_addr,
    input  wire logic [tbcs_pkg::CHAR_W-1:0] rd_data
);

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    tbcs_pkg::state_t            state_reg, state_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [CNT_W-1:0]            idx_reg, idx_next;
    logic                        pend_reg, pend_next;
    logic [tbcs_pkg::CHAR_W-1:0] code_reg, code_next;
    logic                        done_reg, done_next;
    tbcs_pkg::status_t           status_reg, status_next;
    logic                        found_reg, found_next;

    tbcs_pkg::func_t             op;
    logic                        issue;
    logic                        match;
    logic                        scan_end;

    assign op       = tbcs_pkg::func_t'(func);
    assign issue    = (idx_reg < count_reg);
    assign match    = pend_reg && (rd_data == code_reg);
    assign scan_end = pend_reg && (match || !issue);

    assign busy       = (state_reg != tbcs_pkg::S_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign found      = found_reg;
    assign fill_level = tbcs_pkg::FILL_W'(count_reg);
    assign wr_addr    = count_reg[ADDR_W-1:0];
    assign wr_data    = char_code;
    assign rd_addr    = idx_reg[ADDR_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tbcs_pkg::S_IDLE:
            begin
                if (start && op == tbcs_pkg::OP_FIND && count_reg != '0)
                begin
                    state_next = tbcs_pkg::S_SCAN;
                end
            end
            tbcs_pkg::S_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = tbcs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tbcs_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next  = count_reg;
        idx_next    = idx_reg;
        pend_next   = 1'b0;
        code_next   = code_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        found_next  = found_reg;
        wr_en       = 1'b0;
        unique case (state_reg)
            tbcs_pkg::S_IDLE:
            begin
                if (start)
                begin
                    status_next = tbcs_pkg::ST_OK;
                    found_next  = 1'b0;
                    unique case (op)
                        tbcs_pkg::OP_PUSH:
                        begin
                            done_next = 1'b1;
                            if (count_reg == FULL_CNT)
                            begin
                                status_next = tbcs_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        tbcs_pkg::OP_POP:
                        begin
                            done_next = 1'b1;
                            if (count_reg == '0)
                            begin
                                status_next = tbcs_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        tbcs_pkg::OP_CLEAR:
                        begin
                            done_next  = 1'b1;
                            count_next = '0;
                        end
                        tbcs_pkg::OP_FIND:
                        begin
                            code_next = char_code;
                            idx_next  = '0;
                            done_next = (count_reg == '0);
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            tbcs_pkg::S_SCAN:
            begin
                pend_next = issue;
                if (issue)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                if (scan_end)
                begin
                    done_next  = 1'b1;
                    found_next = match;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tbcs_pkg::S_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            pend_reg   <= 1'b0;
            done_reg   <= 1'b0;
            status_reg <= tbcs_pkg::ST_OK;
            found_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            pend_reg   <= pend_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            found_reg  <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("fill count exceeds stack depth");

    a_count_held_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tbcs_pkg::S_SCAN && $past(state_reg == tbcs_pkg::S_SCAN))
            |-> $stable(count_reg))
        else $error("fill count changed during a search");

    a_scan_end_strobes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tbcs_pkg::S_SCAN && scan_end)
            |=> (done_reg && state_reg == tbcs_pkg::S_IDLE))
        else $error("search ended without a result beat");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && found_reg) |-> (status_reg == tbcs_pkg::ST_OK))
        else $error("match reported with a failing status");

endmodule

`default_nettype wire

>>> rtl/core/two_byte_char_stack_with_search.sv
// Top level of the two-byte character stack with search.
// Uses tbcs_pkg and instantiates tbcs_ctrl and tbcs_store.
//
// A command is taken at a rising edge with start high and busy low. Push, pop and
// clear finish in that edge, busy stays low, and the result beat appears on done in
// the next cycle, so a new command may be issued every cycle. Find on a non-empty
// stack holds busy high while the stored characters are read through one memory
// read port and compared one per cycle from the bottom, ending early on a match or
// after the top entry; its result beat appears in the first cycle with busy low again.
// Find on an empty stack behaves like push, pop and clear. Every result is shown
// for exactly one cycle with done high and must be taken then.
`default_nettype none

module two_byte_char_stack_with_search #(
    parameter int DEPTH_CHARS = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [1:0]                  func,
    input  wire logic [tbcs_pkg::CHAR_W-1:0] char_code,
    output logic                             busy,
    output logic                             done,
    output logic [1:0]                       status,
    output logic                             found,
    output logic [tbcs_pkg::FILL_W-1:0]      fill_level
);

    localparam int ADDR_W = $clog2(DEPTH_CHARS);
    localparam int CNT_W  = $clog2(DEPTH_CHARS + 1);

    logic                        wr_en;
    logic [ADDR_W-1:0]           wr_addr;
    logic [tbcs_pkg::CHAR_W-1:0] wr_data;
    logic [ADDR_W-1:0]           rd_addr;
    logic [tbcs_pkg::CHAR_W-1:0] rd_data;

    tbcs_ctrl #(
        .DEPTH  (DEPTH_CHARS),
        .ADDR_W (ADDR_W),
        .CNT_W  (CNT_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .func       (func),
        .char_code  (char_code),
        .busy       (busy),
        .done       (done),
        .status     (status),
        .found      (found),
        .fill_level (fill_level),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    tbcs_store #(
        .DEPTH  (DEPTH_CHARS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the two-byte character stack with search.
// Depends on tbcs_pkg and two_byte_char_stack_with_search; predicts every result beat
// from a local copy of the stack and compares each done beat with the oldest prediction.

module tb;

    localparam int DEPTH = 64;

    typedef struct packed {
        tbcs_pkg::status_t               status;
        logic                            found;
        logic [tbcs_pkg::FILL_W-1:0]     fill;
    } stack_beat_t;

    logic                            clk;
    logic                            rst_n;
    logic                            start;
    logic [1:0]                      func;
    logic [tbcs_pkg::CHAR_W-1:0]     char_code;
    logic                            busy;
    logic                            done;
    logic [1:0]                      status;
    logic                            found;
    logic [tbcs_pkg::FILL_W-1:0]     fill_level;

    logic [tbcs_pkg::CHAR_W-1:0]     held_chars [DEPTH];
    int unsigned                     held_count;
    int unsigned                     written_top;
    stack_beat_t                     pending_beats [$];
    int unsigned                     err_count;
    int unsigned                     sender_idle_pct;

    two_byte_char_stack_with_search #(
        .DEPTH_CHARS(DEPTH)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .func       (func),
        .char_code  (char_code),
        .busy       (busy),
        .done       (done),
        .status     (status),
        .found      (found),
        .fill_level (fill_level)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic stack_beat_t apply_command(tbcs_pkg::func_t op,
                                                  logic [tbcs_pkg::CHAR_W-1:0] code);
        stack_beat_t beat;
        beat.status = tbcs_pkg::ST_OK;
        beat.found  = 1'b0;
        case (op)
            tbcs_pkg::OP_PUSH:
            begin
                if (held_count >= DEPTH)
                begin
                    beat.status = tbcs_pkg::ST_FULL;
                end
                else
                begin
                    held_chars[held_count] = code;
                    held_count++;
                    if (held_count > written_top)
                    begin
                        written_top = held_count;
                    end
                end
            end
            tbcs_pkg::OP_POP:
            begin
                if (held_count == 0)
                begin
                    beat.status = tbcs_pkg::ST_EMPTY;
                end
                else
                begin
                    held_count--;
                end
            end
            tbcs_pkg::OP_CLEAR:
            begin
                held_count = 0;
            end
            default:
            begin
                for (int i = 0; i < held_count; i++)
                begin
                    if (held_chars[i] == code)
                    begin
                        beat.found = 1'b1;
                    end
                end
            end
        endcase
        beat.fill = held_count[tbcs_pkg::FILL_W-1:0];
        return beat;
    endfunction

    task automatic send_command(tbcs_pkg::func_t op, logic [tbcs_pkg::CHAR_W-1:0] code);
        int unsigned gap;
        gap = 0;
        if ($urandom_range(0, 99) < sender_idle_pct)
        begin
            gap = $urandom_range(1, 4);
        end
        repeat (gap)
        begin
            @(negedge clk);
            start     <= 1'b0;
            func      <= 2'($urandom);
            char_code <= 16'($urandom);
        end
        @(negedge clk);
        start     <= 1'b1;
        func      <= op;
        char_code <= code;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        pending_beats.push_back(apply_command(op, code));
    endtask

    always @(posedge clk)
    begin
        stack_beat_t want;
        if (rst_n && done)
        begin
            if (pending_beats.size() == 0)
            begin
                $error("result beat with no command outstanding");
                err_count++;
            end
            else
            begin
                want = pending_beats.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    err_count++;
                end
                if (found !== want.found)
                begin
                    $error("found: expected %0d, got %0d", want.found, found);
                    err_count++;
                end
                if (fill_level !== want.fill)
                begin
                    $error("fill_level: expected %0d, got %0d", want.fill, fill_level);
                    err_count++;
                end
            end
        end
    end

    function automatic logic [tbcs_pkg::CHAR_W-1:0] pick_find_code();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 50 && held_count > 0)
        begin
            return held_chars[$urandom_range(0, held_count - 1)];
        end
        if (pick < 70 && written_top > held_count)
        begin
            return held_chars[$urandom_range(held_count, written_top - 1)];
        end
        return 16'($urandom);
    endfunction

    function automatic tbcs_pkg::func_t pick_op(int unsigned push_w, int unsigned pop_w,
                                                int unsigned clear_w);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < push_w)
        begin
            return tbcs_pkg::OP_PUSH;
        end
        if (roll < push_w + pop_w)
        begin
            return tbcs_pkg::OP_POP;
        end
        if (roll < push_w + pop_w + clear_w)
        begin
            return tbcs_pkg::OP_CLEAR;
        end
        return tbcs_pkg::OP_FIND;
    endfunction

    task automatic send_random(int unsigned push_w, int unsigned pop_w, int unsigned clear_w);
        tbcs_pkg::func_t op;
        op = pick_op(push_w, pop_w, clear_w);
        if (op == tbcs_pkg::OP_FIND)
        begin
            send_command(op, pick_find_code());
        end
        else if (op == tbcs_pkg::OP_PUSH && held_count > 0 && $urandom_range(0, 9) == 0)
        begin
            send_command(op, held_chars[$urandom_range(0, held_count - 1)]);
        end
        else
        begin
            send_command(op, 16'($urandom));
        end
    endtask

    task automatic test_directed();
        sender_idle_pct = 0;
        send_command(tbcs_pkg::OP_POP,   16'hFFFF);
        send_command(tbcs_pkg::OP_FIND,  16'h0000);
        send_command(tbcs_pkg::OP_CLEAR, 16'hFFFF);
        send_command(tbcs_pkg::OP_PUSH,  16'h0000);
        send_command(tbcs_pkg::OP_PUSH,  16'hFFFF);
        send_command(tbcs_pkg::OP_PUSH,  16'h8001);
        send_command(tbcs_pkg::OP_FIND,  16'hFFFF);
        send_command(tbcs_pkg::OP_FIND,  16'h0000);
        send_command(tbcs_pkg::OP_FIND,  16'h8001);
        send_command(tbcs_pkg::OP_FIND,  16'h7FFE);
        send_command(tbcs_pkg::OP_FIND,  16'h0001);
        send_command(tbcs_pkg::OP_POP,   16'h0000);
        send_command(tbcs_pkg::OP_FIND,  16'h8001);
        send_command(tbcs_pkg::OP_POP,   16'hAAAA);
        send_command(tbcs_pkg::OP_POP,   16'h5555);
        send_command(tbcs_pkg::OP_POP,   16'h0000);
        send_command(tbcs_pkg::OP_PUSH,  16'h5555);
        send_command(tbcs_pkg::OP_PUSH,  16'hAAAA);
        send_command(tbcs_pkg::OP_FIND,  16'hAAAA);
        send_command(tbcs_pkg::OP_CLEAR, 16'h0000);
        send_command(tbcs_pkg::OP_FIND,  16'h5555);
        send_command(tbcs_pkg::OP_POP,   16'h1234);
    endtask

    // The stack is filled to the top, pushed past it, searched at both ends, then popped, pushed and cleared.
    task automatic test_overflow();
        sender_idle_pct = 0;
        while (held_count < DEPTH)
        begin
            send_command(tbcs_pkg::OP_PUSH, 16'($urandom));
        end
        send_command(tbcs_pkg::OP_PUSH, 16'hFFFF);
        send_command(tbcs_pkg::OP_PUSH, 16'h0000);
        send_command(tbcs_pkg::OP_FIND, held_chars[DEPTH - 1]);
        send_command(tbcs_pkg::OP_FIND, held_chars[0]);
        send_command(tbcs_pkg::OP_FIND, 16'($urandom));
        send_command(tbcs_pkg::OP_POP,  16'h0000);
        send_command(tbcs_pkg::OP_FIND, held_chars[DEPTH - 1]);
        send_command(tbcs_pkg::OP_PUSH, 16'hC0DE);
        send_command(tbcs_pkg::OP_PUSH, 16'hBEEF);
        send_command(tbcs_pkg::OP_CLEAR, 16'h0000);
    endtask

    task automatic test_random();
        int unsigned idle_setting [3];
        idle_setting = '{0, 62, 11};
        foreach (idle_setting[p])
        begin
            sender_idle_pct = idle_setting[p];
            for (int n = 0; n < 595; n++)
            begin
                case ((n / 100) % 3)
                    0: send_random(60, 10, 2);
                    1: send_random(25, 50, 3);
                    default: send_random(40, 30, 5);
                endcase
            end
        end
    endtask

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        start           = 1'b0;
        func            = tbcs_pkg::OP_PUSH;
        char_code       = '0;
        held_count      = 0;
        written_top     = 0;
        err_count       = 0;
        sender_idle_pct = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_overflow();
        test_random();

        @(negedge clk);
        start <= 1'b0;
        while (pending_beats.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (80) @(posedge clk);
        if (err_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/tbcs_pkg.sv
rtl/core/tbcs_store.sv
rtl/core/tbcs_ctrl.sv
rtl/core/two_byte_char_stack_with_search.sv
tb/sv/tb.sv
